// ===== rtl/core/pcfs_pkg.sv =====
// Shared types and constants for the periodic CAN frame scheduler.
package pcfs_pkg;

    // Standard CAN identifiers of the emitted frames
    localparam logic [10:0] ID_CLUSTER_LAMPS = 11'h545;
    localparam logic [10:0] ID_CLUSTER_RPM   = 11'h316;
    localparam logic [10:0] ID_CLUSTER_TEMP  = 11'h329;
    localparam logic [10:0] ID_HEARTBEAT     = 11'h285;
    localparam logic [10:0] ID_CHARGE        = 11'h286;

    // Consumption counter clears at or above this value
    localparam logic [16:0] CONSUMPTION_WRAP = 17'd65534;
    // Heartbeat byte 2 when EVSE pull is requested
    localparam logic [7:0]  EVSE_ON_CODE     = 8'hB6;
    // ceil(2^21 / 5): rpm * 32 / 5 == (rpm * RPM_RECIP) >> 16 for rpm < 2^14
    localparam logic [18:0] RPM_RECIP        = 19'd419431;

    // Configuration register indexes
    localparam logic [1:0]  REG_CLUSTER_PERIOD   = 2'd0;
    localparam logic [1:0]  REG_HEARTBEAT_PERIOD = 2'd1;
    localparam logic [1:0]  REG_CHARGE_PERIOD    = 2'd2;

    // Pending-frame bit positions in the back end, in send order
    localparam int P_LAMPS = 0;
    localparam int P_RPM   = 1;
    localparam int P_TEMP  = 2;
    localparam int P_HB    = 3;
    localparam int P_CHG   = 4;

    // One classified tick: which frames are due and their variable bytes
    typedef struct packed {
        logic        cluster;
        logic        heartbeat;
        logic        charge;
        logic [15:0] count;
        logic [15:0] disp;
        logic [7:0]  temp2;
        logic        evse;
        logic [15:0] volt;
        logic [7:0]  curr;
    } t_job;

endpackage

// ===== rtl/core/pcfs_front.sv =====
// Front end: period registers, timers, consumption counter, tick classification.
module pcfs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_accept,
    input  logic [31:0]      i_now_ms,
    input  logic [13:0]      i_engine_rpm,
    input  logic [7:0]       i_coolant_temp,
    input  logic [15:0]      i_consumption_increment,
    input  logic             i_evse_pull,
    input  logic             i_charging_on,
    input  logic [15:0]      i_voltage_request,
    input  logic [7:0]       i_current_request,
    output logic             o_push,
    output pcfs_pkg::t_job   o_job
);
    import pcfs_pkg::*;

    logic [15:0] r_cl_period, r_hb_period, r_ch_period;
    logic [31:0] r_cl_last, r_hb_last, r_ch_last;
    logic [15:0] r_count;

    logic [31:0] cl_elapsed, hb_elapsed, ch_elapsed;
    logic        cl_due, hb_due, ch_due;
    logic [16:0] sum;
    logic [15:0] n_count;
    logic [32:0] rpm_prod;

    assign cl_elapsed = i_now_ms - r_cl_last;
    assign hb_elapsed = i_now_ms - r_hb_last;
    assign ch_elapsed = i_now_ms - r_ch_last;
    assign cl_due = cl_elapsed >= {16'd0, r_cl_period};
    assign hb_due = hb_elapsed >= {16'd0, r_hb_period};
    assign ch_due = i_charging_on && (ch_elapsed >= {16'd0, r_ch_period});

    assign sum     = {1'b0, r_count} + {1'b0, i_consumption_increment};
    assign n_count = (sum >= CONSUMPTION_WRAP) ? 16'd0 : sum[15:0];

    // rpm * 6.4 by reciprocal multiply; result lands in the queue register
    assign rpm_prod = {19'd0, i_engine_rpm} * {14'd0, RPM_RECIP};

    always_comb begin
        o_job.cluster   = cl_due;
        o_job.heartbeat = hb_due;
        o_job.charge    = ch_due;
        o_job.count     = n_count;
        o_job.disp      = rpm_prod[31:16];
        o_job.temp2     = {i_coolant_temp[6:0], 1'b0};
        o_job.evse      = i_evse_pull;
        o_job.volt      = i_voltage_request;
        o_job.curr      = i_current_request;
    end

    assign o_push = i_accept && (cl_due || hb_due || ch_due);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_period <= 16'd100;
            r_hb_period <= 16'd100;
            r_ch_period <= 16'd800;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CLUSTER_PERIOD:   r_cl_period <= i_cfg_data;
                REG_HEARTBEAT_PERIOD: r_hb_period <= i_cfg_data;
                REG_CHARGE_PERIOD:    r_ch_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_last <= 32'd0;
            r_hb_last <= 32'd0;
            r_ch_last <= 32'd0;
            r_count   <= 16'd0;
        end else if (i_accept) begin
            if (cl_due) begin
                r_cl_last <= i_now_ms;
                r_count   <= n_count;
            end
            if (hb_due) begin
                r_hb_last <= i_now_ms;
            end
            if (ch_due) begin
                r_ch_last <= i_now_ms;
            end
        end
    end

endmodule

// ===== rtl/core/pcfs_queue.sv =====
// Short FIFO of classified ticks between front and back end.
module pcfs_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcfs_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output pcfs_pkg::t_job   o_job
);
    import pcfs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == CW'(DEPTH);
    assign o_job   = r_mem[r_rptr];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue pop while empty");

endmodule

// ===== rtl/core/pcfs_back.sv =====
// Back end: puts one queued tick's frames into the output register, one per unstalled cycle.
module pcfs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  pcfs_pkg::t_job   i_q_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [10:0]      o_frame_id,
    output logic [63:0]      o_frame_data,
    output logic             o_last
);
    import pcfs_pkg::*;

    t_job        r_job;
    logic        r_busy;
    logic [4:0]  r_pend;
    logic        r_valid;
    logic [10:0] r_id;
    logic [63:0] r_data;
    logic        r_last;

    logic        load;
    logic [4:0]  rest;
    logic        last;
    logic [10:0] sel_id;
    logic [63:0] sel_data;

    assign load = r_busy && (!r_valid || i_ready);
    assign rest = r_pend & (r_pend - 5'd1);
    assign last = rest == 5'd0;
    assign o_pop = i_q_valid && (!r_busy || (load && last));

    always_comb begin
        priority if (r_pend[P_LAMPS]) begin
            sel_id   = ID_CLUSTER_LAMPS;
            sel_data = {8'h18, 8'h00, 8'h10, 8'h7E, 8'h00,
                        r_job.count[15:8], r_job.count[7:0], 8'h00};
        end else if (r_pend[P_RPM]) begin
            sel_id   = ID_CLUSTER_RPM;
            sel_data = {8'h62, 8'h00, 8'h12, 8'h65,
                        r_job.disp[15:8], r_job.disp[7:0], 8'h62, 8'h05};
        end else if (r_pend[P_TEMP]) begin
            sel_id   = ID_CLUSTER_TEMP;
            sel_data = {8'h00, 8'h00, 8'hEE, 8'h00,
                        8'h19, 8'hB2, r_job.temp2, 8'hD9};
        end else if (r_pend[P_HB]) begin
            sel_id   = ID_HEARTBEAT;
            sel_data = {40'd0, (r_job.evse ? EVSE_ON_CODE : 8'h00), 16'd0};
        end else begin
            sel_id   = ID_CHARGE;
            sel_data = {8'h00, 8'h0A, 8'h00, 8'h00, 8'h37,
                        r_job.curr, r_job.volt[15:8], r_job.volt[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (load) begin
            r_id   <= sel_id;
            r_data <= sel_data;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pend  <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pend <= {i_q_job.charge, i_q_job.heartbeat,
                           {3{i_q_job.cluster}}};
            end else if (load) begin
                r_pend <= rest;
                r_busy <= !last;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_id   = r_id;
    assign o_frame_data = r_data;
    assign o_last       = r_last;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pend != 5'd0)
        else $error("back end busy with no frame pending");

    a_tick_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_busy)
        else $error("non-final frame shown but rest of tick lost");

endmodule

// ===== rtl/core/periodic_can_frame_scheduler.sv =====
// Top level of the periodic CAN frame scheduler.
//
// Usage:
//  - s_axis carries one scheduling tick per request (current ms time plus
//    live vehicle values). A tick is taken whenever the tick queue has room,
//    independent of the output side.
//  - Three period timers (cluster, heartbeat, charger) are tested against the
//    tick time with modulo 2^32 elapsed time; each due timer reloads to now.
//  - m_axis emits 0 to 5 frames per tick, in order 0x545, 0x316, 0x329,
//    0x285, 0x286; tlast marks the final frame of a tick. A tick with no due
//    timer produces no request on m_axis.
//  - The cfg port writes the three period registers; its ready is always high.
//    Write only while the block is idle.
// Path: tick -> queue -> frame expander -> output register (m_axis).
// Throughput: one frame per cycle on m_axis while m_axis_tready is high;
//   a tick holds the frame expander until all its frames (up to 5) are loaded;
//   up to QUEUE_DEPTH ticks wait in the queue, taken each cycle until it fills.
// Reset: periods return to 100/100/800 ms, timers and consumption count to 0,
//   queue and output register empty.
// Stall: when m_axis_tready is low the frame holds in the output register;
//   the queue then fills and s_axis_tready drops.
module periodic_can_frame_scheduler #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write request
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    // tick input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] now_ms, [45:32] engine_rpm, [53:46] coolant_temp,
    // [69:54] consumption_increment, [70] evse_pull, [71] charging_on,
    // [87:72] voltage_request, [95:88] current_request
    input  logic [95:0]  s_axis_tdata,
    // frame output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] frame_data
    output logic [63:0]  m_axis_tdata,
    // [10:0] frame_id
    output logic [10:0]  m_axis_tuser,
    output logic         m_axis_tlast
);
    import pcfs_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    logic accept;
    t_job front_job;
    t_job head_job;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    pcfs_front u_front (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_accept                (accept),
        .i_now_ms                (s_axis_tdata[31:0]),
        .i_engine_rpm            (s_axis_tdata[45:32]),
        .i_coolant_temp          (s_axis_tdata[53:46]),
        .i_consumption_increment (s_axis_tdata[69:54]),
        .i_evse_pull             (s_axis_tdata[70]),
        .i_charging_on           (s_axis_tdata[71]),
        .i_voltage_request       (s_axis_tdata[87:72]),
        .i_current_request       (s_axis_tdata[95:88]),
        .o_push                  (push),
        .o_job                   (front_job)
    );

    pcfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (head_job)
    );

    pcfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (head_job),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_frame_id   (m_axis_tuser),
        .o_frame_data (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule
